// ===== hdl/jcs_pkg.sv =====
// Shared types and character codes for the JSON-with-comments stripper.
package jcs_pkg;

   // Character codes that steer the scanner.
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Scanner state carried from one byte to the next.
   typedef struct packed {
      logic inside_string;
      logic escape_pending;
      logic inside_line_comment;
      logic inside_block_comment;
      logic slash_held;
      logic star_seen;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '0;

   // One result word.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_result;
   } result_type;

   // Results caused by one input word: a count of zero, one or two and the words.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_result_type;

endpackage

// ===== hdl/jsonc_comment_stripper.sv =====
// Top level of the JSON-with-comments stripper: input register, scanner state and result queue.
//
// The block takes one byte of commented JSON text per word and returns the text with line
// and block comments removed; newlines within comments are kept and slashes inside quoted
// strings are left alone. A byte enters the input register, is scanned against the stored
// state and is written into a four-word result queue, whose head drives the result port.
// One byte is taken every cycle while the queue has room; a byte that releases a held slash
// yields two result words, and while the queue holds more than two words the input stalls
// until it drains, so the sustained rate is one word out per cycle unless the receiver stalls.
// A final byte that yields no text produces one word with rsp_byte_valid low and
// rsp_last_result high, and all scanner state returns to its reset value after the final byte.
module jsonc_comment_stripper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last_result
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     in_eot_ff;
   jcs_pkg::scan_state_type  state_ff;
   jcs_pkg::scan_state_type  state_in;
   jcs_pkg::scan_state_type  state_next;
   jcs_pkg::step_result_type step_out;
   jcs_pkg::step_result_type push;
   logic                     room;
   logic                     advance;
   logic                     load;

   // The registered word moves on when the queue has room for its results.
   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign load      = req_valid && !req_stall;

   assign in_valid_in = load || (in_valid_ff && !advance);
   assign state_in    = advance ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= jcs_pkg::SCAN_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   // Input word register.
   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff <= req_in_byte;
         in_eot_ff  <= req_end_of_text;
      end
   end

   jcs_step u_step (
      .state       (state_ff),
      .in_byte     (in_byte_ff),
      .end_of_text (in_eot_ff),
      .state_next  (state_next),
      .results     (step_out)
   );

   // Only a word that advances pushes results.
   always_comb begin
      push = step_out;
      if (!advance) push.count = 2'd0;
   end

   jcs_out_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .room            (room),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_result (rsp_last_result)
   );

`ifndef SYNTHESIS
   // Every advancing word yields at least one result at the end of the text.
   a_eot_result: assert property (@(posedge clock) disable iff (reset)
      advance && in_eot_ff |-> step_out.count != 2'd0)
      else $error("final byte produced no result");

   // After the final byte the scanner state is back at reset.
   a_eot_clear: assert property (@(posedge clock) disable iff (reset)
      advance && in_eot_ff |=> state_ff == jcs_pkg::SCAN_RESET)
      else $error("state not cleared after final byte");

   // A stalled input word holds in the register.
   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eot_ff))
      else $error("input register lost a stalled word");
`endif

endmodule

// ===== hdl/jcs_step.sv =====
// Combinational scanner step: next state and the results of one input byte.
module jcs_step (
   input  jcs_pkg::scan_state_type  state,
   input  logic [7:0]               in_byte,
   input  logic                     end_of_text,
   output jcs_pkg::scan_state_type  state_next,
   output jcs_pkg::step_result_type results
);

   // String tracking for a byte that is passed through as text.
   function automatic jcs_pkg::scan_state_type string_track(
      input jcs_pkg::scan_state_type s,
      input logic [7:0]              b
   );
      jcs_pkg::scan_state_type r;
      r = s;
      if (!s.inside_string) begin
         if (b == jcs_pkg::CH_QUOTE) r.inside_string = 1'b1;
      end else if (s.escape_pending) begin
         r.escape_pending = 1'b0;
      end else if (b == jcs_pkg::CH_BACKSLASH) begin
         r.escape_pending = 1'b1;
      end else if (b == jcs_pkg::CH_QUOTE) begin
         r.inside_string = 1'b0;
      end
      return r;
   endfunction

   jcs_pkg::scan_state_type nxt;
   jcs_pkg::result_type     r0;
   jcs_pkg::result_type     r1;
   logic [1:0]              n;

   // Main scanner decision, in order of precedence.
   always_comb begin
      nxt = state;
      n   = 2'd0;
      r0  = '{out_byte: in_byte, byte_valid: 1'b1, last_result: 1'b0};
      r1  = '{out_byte: in_byte, byte_valid: 1'b1, last_result: 1'b0};
      priority if (state.inside_line_comment) begin
         if (in_byte == jcs_pkg::CH_NEWLINE) begin
            nxt.inside_line_comment = 1'b0;
            n = 2'd1;
         end
      end else if (state.inside_block_comment) begin
         if (state.star_seen && in_byte == jcs_pkg::CH_SLASH) begin
            nxt.inside_block_comment = 1'b0;
            nxt.star_seen            = 1'b0;
         end else begin
            nxt.star_seen = (in_byte == jcs_pkg::CH_STAR);
            if (in_byte == jcs_pkg::CH_NEWLINE) n = 2'd1;
         end
      end else if (state.slash_held) begin
         nxt.slash_held = 1'b0;
         if (in_byte == jcs_pkg::CH_SLASH) begin
            nxt.inside_line_comment = 1'b1;
         end else if (in_byte == jcs_pkg::CH_STAR) begin
            nxt.inside_block_comment = 1'b1;
            nxt.star_seen            = 1'b0;
         end else begin
            // The held slash was ordinary text: it goes out ahead of this byte.
            r0.out_byte = jcs_pkg::CH_SLASH;
            n   = 2'd2;
            nxt = string_track(nxt, in_byte);
         end
      end else if (!state.inside_string && in_byte == jcs_pkg::CH_SLASH) begin
         if (end_of_text) n = 2'd1;
         else nxt.slash_held = 1'b1;
      end else begin
         n   = 2'd1;
         nxt = string_track(nxt, in_byte);
      end

      // The final byte closes the text: mark the last result and clear the state.
      if (end_of_text) begin
         if (n == 2'd0) begin
            r0 = '{out_byte: 8'h00, byte_valid: 1'b0, last_result: 1'b0};
            n  = 2'd1;
         end
         if (n == 2'd1) r0.last_result = 1'b1;
         else r1.last_result = 1'b1;
         nxt = jcs_pkg::SCAN_RESET;
      end
   end

   assign state_next     = nxt;
   assign results.count  = n;
   assign results.first  = r0;
   assign results.second = r1;

endmodule

// ===== hdl/jcs_out_queue.sv =====
// Small result queue that takes up to two words a cycle and delivers one unless the receiver stalls.
module jcs_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  jcs_pkg::step_result_type push,
   output logic                     room,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_last_result
);

   jcs_pkg::result_type             entry_ff [jcs_pkg::QUEUE_DEPTH];
   logic [jcs_pkg::QUEUE_AW-1:0]    wr_ptr_ff;
   logic [jcs_pkg::QUEUE_AW-1:0]    wr_ptr_in;
   logic [jcs_pkg::QUEUE_AW-1:0]    rd_ptr_ff;
   logic [jcs_pkg::QUEUE_AW-1:0]    rd_ptr_in;
   logic [jcs_pkg::QUEUE_CW-1:0]    count_ff;
   logic [jcs_pkg::QUEUE_CW-1:0]    count_in;
   logic [jcs_pkg::QUEUE_AW-1:0]    wr_ptr_plus1;
   logic                            pop;
   jcs_pkg::result_type             head;

   // There is room for a whole step's results when at least two entries are free.
   assign room = (count_ff <= jcs_pkg::QUEUE_CW'(jcs_pkg::QUEUE_DEPTH - 2));

   assign pop          = rsp_valid && !rsp_stall;
   assign wr_ptr_plus1 = wr_ptr_ff + 1'b1;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + jcs_pkg::QUEUE_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + jcs_pkg::QUEUE_AW'(pop);
      count_in  = count_ff + jcs_pkg::QUEUE_CW'(push.count) - jcs_pkg::QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage: the first word at the write pointer, the second just after it.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_ptr_plus1] <= push.second;
   end

   // The head entry drives the result port.
   assign head            = entry_ff[rd_ptr_ff];
   assign rsp_valid       = (count_ff != '0);
   assign rsp_out_byte    = head.out_byte;
   assign rsp_byte_valid  = head.byte_valid;
   assign rsp_last_result = head.last_result;

`ifndef SYNTHESIS
   // The queue never holds more words than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= jcs_pkg::QUEUE_CW'(jcs_pkg::QUEUE_DEPTH))
      else $error("result queue over-full");

   // Words are only pushed while there is room for a full step.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("result pushed without room");

   // A step never reports three results.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd3)
      else $error("invalid result count");

   // The fill count follows pushes and pops exactly.
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + jcs_pkg::QUEUE_CW'($past(push.count))
                                    - jcs_pkg::QUEUE_CW'($past(pop)))
      else $error("result queue count out of step");
`endif

endmodule

// ===== dv/jsonc_comment_stripper_tb.sv =====
// Self-checking testbench for the JSON-with-comments stripper, with its own comment-stripping model.
module jsonc_comment_stripper_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TEXT_BYTES   = 1950;
   localparam int QUIET_FROM   = 300;
   localparam int QUIET_TO     = 750;
   localparam int HOLD_AT      = 450;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [7:0] value;
      logic       fin;
   } text_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last_result;

   // Bytes waiting to be offered, the text under construction and the expected output words.
   text_byte_type       pending_bytes[$];
   logic [7:0]          text_buf[$];
   jcs_pkg::result_type expected_words[$];

   // Model of the scanner state.
   logic quote_open, escape_next, line_cmt_open, block_cmt_open, slash_waiting, star_last;
   int   words_this_byte;

   int                  bytes_taken = 0;
   int                  cycle_count = 0;
   int                  errors = 0;
   int                  hold_left = 0;
   logic                hold_begun = 1'b0;
   text_byte_type       nxt_word;
   jcs_pkg::result_type got_word;
   jcs_pkg::result_type want_word;

   jsonc_comment_stripper uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_result (rsp_last_result)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Neither side inserts random gaps for a long stretch in the middle of the run.
   function automatic int idle_pct();
      return (bytes_taken >= QUIET_FROM && bytes_taken < QUIET_TO) ? 0 : 38;
   endfunction

   // ---------------------------------------------------------------- model of the stripper

   task automatic clear_scan_state();
      quote_open     = 1'b0;
      escape_next    = 1'b0;
      line_cmt_open  = 1'b0;
      block_cmt_open = 1'b0;
      slash_waiting  = 1'b0;
      star_last      = 1'b0;
   endtask

   task automatic put_word(input logic [7:0] b);
      jcs_pkg::result_type w;
      w.out_byte    = b;
      w.byte_valid  = 1'b1;
      w.last_result = 1'b0;
      expected_words.insert(expected_words.size(), w);
      words_this_byte++;
   endtask

   // A byte that is passed through as text; it also steers the string and escape tracking.
   task automatic pass_text(input logic [7:0] b);
      put_word(b);
      if (!quote_open) begin
         if (b == jcs_pkg::CH_QUOTE) quote_open = 1'b1;
      end else if (escape_next) begin
         escape_next = 1'b0;
      end else if (b == jcs_pkg::CH_BACKSLASH) begin
         escape_next = 1'b1;
      end else if (b == jcs_pkg::CH_QUOTE) begin
         quote_open = 1'b0;
      end
   endtask

   task automatic strip_byte(input logic [7:0] b, input logic fin);
      jcs_pkg::result_type w;
      words_this_byte = 0;
      if (line_cmt_open) begin
         if (b == jcs_pkg::CH_NEWLINE) begin
            line_cmt_open = 1'b0;
            put_word(b);
         end
      end else if (block_cmt_open) begin
         if (star_last && b == jcs_pkg::CH_SLASH) begin
            block_cmt_open = 1'b0;
            star_last      = 1'b0;
         end else begin
            star_last = (b == jcs_pkg::CH_STAR);
            if (b == jcs_pkg::CH_NEWLINE) put_word(b);
         end
      end else if (slash_waiting) begin
         slash_waiting = 1'b0;
         if (b == jcs_pkg::CH_SLASH) begin
            line_cmt_open = 1'b1;
         end else if (b == jcs_pkg::CH_STAR) begin
            block_cmt_open = 1'b1;
            star_last      = 1'b0;
         end else begin
            put_word(jcs_pkg::CH_SLASH);
            pass_text(b);
         end
      end else if (!quote_open && b == jcs_pkg::CH_SLASH) begin
         if (fin) put_word(b);
         else slash_waiting = 1'b1;
      end else begin
         pass_text(b);
      end

      // The final byte marks its last word, or yields a bare end marker, and clears the state.
      if (fin) begin
         if (words_this_byte == 0) begin
            w = '0;
         end else begin
            w = expected_words.pop_back();
         end
         w.last_result = 1'b1;
         expected_words.insert(expected_words.size(), w);
         clear_scan_state();
      end
   endtask

   // ---------------------------------------------------------------- text generation

   task automatic add(input logic [7:0] b);
      text_buf.insert(text_buf.size(), b);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) add(s[i]);
   endtask

   // Moves the text under construction to the send queue, flagging its final byte.
   task automatic close_text();
      text_byte_type t;
      while (text_buf.size() != 0) begin
         t.value = text_buf.pop_front();
         t.fin   = (text_buf.size() == 0);
         pending_bytes.insert(pending_bytes.size(), t);
      end
   endtask

   function automatic logic [7:0] plain_char();
      string alphabet;
      alphabet = "{}[]:,. -+0123456789abcdefnrtuxyzAEZ";
      return alphabet[$urandom_range(0, alphabet.len() - 1)];
   endfunction

   // Arbitrary bytes half of the time and the steering characters otherwise.
   function automatic logic [7:0] noisy_char();
      case ($urandom_range(0, 9))
         0: return jcs_pkg::CH_SLASH;
         1: return jcs_pkg::CH_STAR;
         2: return jcs_pkg::CH_QUOTE;
         3: return jcs_pkg::CH_BACKSLASH;
         4: return jcs_pkg::CH_NEWLINE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // One well-formed piece of commented JSON text.
   task automatic add_token();
      case ($urandom_range(0, 6))
         0, 1: repeat ($urandom_range(1, 4)) add(plain_char());
         2: begin
            add(jcs_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 5)) begin
               case ($urandom_range(0, 4))
                  0: add(jcs_pkg::CH_SLASH);
                  1: add(jcs_pkg::CH_STAR);
                  2: begin
                     add(jcs_pkg::CH_BACKSLASH);
                     add(noisy_char());
                  end
                  default: add(plain_char());
               endcase
            end
            add(jcs_pkg::CH_QUOTE);
         end
         3: begin
            add(jcs_pkg::CH_SLASH);
            add(jcs_pkg::CH_SLASH);
            repeat ($urandom_range(0, 5)) begin
               case ($urandom_range(0, 3))
                  0: add(jcs_pkg::CH_SLASH);
                  1: add(jcs_pkg::CH_STAR);
                  2: add(jcs_pkg::CH_QUOTE);
                  default: add(plain_char());
               endcase
            end
            add(jcs_pkg::CH_NEWLINE);
         end
         4: begin
            add(jcs_pkg::CH_SLASH);
            add(jcs_pkg::CH_STAR);
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 4))
                  0: add(jcs_pkg::CH_STAR);
                  1: add(jcs_pkg::CH_SLASH);
                  2: add(jcs_pkg::CH_NEWLINE);
                  3: add(jcs_pkg::CH_QUOTE);
                  default: add(plain_char());
               endcase
            end
            add(jcs_pkg::CH_STAR);
            add(jcs_pkg::CH_SLASH);
         end
         5: begin
            add(jcs_pkg::CH_SLASH);
            add(plain_char());
         end
         default: add(jcs_pkg::CH_NEWLINE);
      endcase
   endtask

   task automatic build_random_text();
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 20)) add(noisy_char());
      end else begin
         repeat ($urandom_range(1, 8)) add_token();
      end
      // Sometimes the text stops on or just after a slash.
      case ($urandom_range(0, 9))
         0: add(jcs_pkg::CH_SLASH);
         1: begin
            add(jcs_pkg::CH_SLASH);
            add(jcs_pkg::CH_SLASH);
         end
         2: begin
            add(jcs_pkg::CH_SLASH);
            add(jcs_pkg::CH_STAR);
         end
         default: ;
      endcase
      close_text();
   endtask

   // ---------------------------------------------------------------- sender

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_scan_state();
      end else begin
         if (req_valid && !req_stall) begin
            strip_byte(req_in_byte, req_end_of_text);
            bytes_taken <= bytes_taken + 1;
         end
         if (req_valid && req_stall) begin
            // A stalled word is held as it is.
         end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
            nxt_word = pending_bytes.pop_front();
            req_valid       <= 1'b1;
            req_in_byte     <= nxt_word.value;
            req_end_of_text <= nxt_word.fin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // One long hold-off lets the result queue fill so that the input has to stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_left  <= 0;
         hold_begun <= 1'b0;
      end else if (!hold_begun && bytes_taken >= HOLD_AT) begin
         hold_begun <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < idle_pct());
      end
   end

   // Each accepted result word is checked against the oldest expected word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_word = {rsp_out_byte, rsp_byte_valid, rsp_last_result};
         if (expected_words.size() == 0) begin
            errors <= errors + 1;
            $display({"%0t: unexpected word: expected none, got out_byte %h byte_valid %b ",
                      "last_result %b"}, $time, rsp_out_byte, rsp_byte_valid, rsp_last_result);
         end else begin
            want_word = expected_words.pop_front();
            if (got_word !== want_word) begin
               errors <= errors + 1;
               $display({"%0t: mismatch: out_byte exp %h got %h, byte_valid exp %b got %b, ",
                         "last_result exp %b got %b"}, $time,
                        want_word.out_byte, rsp_out_byte,
                        want_word.byte_valid, rsp_byte_valid,
                        want_word.last_result, rsp_last_result);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus and end of run

   initial begin
      // Byte extremes, a string with an escaped quote and slashes, and a held slash that
      // is released by the final byte.
      add(8'h00);
      add(8'hFF);
      add_str("\"/\\\"\"/x");
      close_text();
      // A block comment whose opener is followed by a slash, a kept newline, then a new
      // slash as the final byte.
      add_str("/*/\n*//");
      close_text();
      // A line comment, then a comment opened by the final byte.
      add_str("//q\n//");
      close_text();
      // An unclosed block comment and an unclosed string with an escape pending.
      add_str("/*");
      close_text();
      add_str("\"\\");
      close_text();

      while (pending_bytes.size() < TEXT_BYTES) build_random_text();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while ((pending_bytes.size() != 0 || req_valid || expected_words.size() != 0)
             && cycle_count < CYCLE_LIMIT)
         @(posedge clock);

      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (errors == 0 && expected_words.size() == 0) begin
            $display("*** PASSED ***");
         end else begin
            $display("*** FAILED ***");
         end
      end
      $finish;
   end

endmodule
